@@ sv/mexp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants
// Command codes, sequencer states and word sizes for the 256-bit modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int OpWordsDef = 4;   // default operand size in 64-bit words
    localparam int WordW      = 64;  // storage word
    localparam int LimbW      = 32;  // multiplier limb
    localparam int ModWords   = 4;   // modulus configuration words
    localparam int CfgIdxW    = 2;
    localparam int CmdW       = 2;
    localparam int IdxW       = 2;

    typedef enum logic [CmdW-1:0] {
        CMD_LOAD_BASE = 2'd0,
        CMD_LOAD_EXP  = 2'd1,
        CMD_POWER     = 2'd2,
        CMD_INVERSE   = 2'd3
    } t_cmd;

    // main sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WB,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_RED_WAIT,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_OUT_RD,
        ST_OUT
    } t_state;

    // what the running modular product belongs to
    typedef enum logic [1:0] {
        PH_INIT,
        PH_SQR,
        PH_MUL
    } t_phase;

    // reduction unit
    typedef enum logic [1:0] {
        RD_IDLE,
        RD_PRE,
        RD_LOAD,
        RD_RUN
    } t_red_state;

endpackage

@@ sv/mexp_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_store: operand memories
// Base, exponent and accumulator word memories. Base and exponent read as
// zero until written; the accumulator has two read ports for squaring.
// ----------------------------------------------------------------------------
module mexp_store #(
    parameter int OW = mexp_pkg::OpWordsDef,
    localparam int AW = $clog2(OW)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // operand loads
    input  logic                       i_base_we,
    input  logic                       i_exp_we,
    input  logic [AW-1:0]              i_ld_addr,
    input  logic [mexp_pkg::WordW-1:0] i_ld_data,
    // accumulator write back
    input  logic                       i_acc_we,
    input  logic [AW-1:0]              i_acc_waddr,
    input  logic [mexp_pkg::WordW-1:0] i_acc_wdata,
    // reads, registered: data in the cycle after the address
    input  logic [AW-1:0]              i_acc_ra,
    input  logic [AW-1:0]              i_acc_rb,
    input  logic [AW-1:0]              i_base_ra,
    input  logic [AW-1:0]              i_exp_ra,
    output logic [mexp_pkg::WordW-1:0] o_acc_da,
    output logic [mexp_pkg::WordW-1:0] o_acc_db,
    output logic [mexp_pkg::WordW-1:0] o_base_d,
    output logic [mexp_pkg::WordW-1:0] o_exp_d
);
    import mexp_pkg::*;

    logic [WordW-1:0] r_base_mem [OW];
    logic [WordW-1:0] r_exp_mem  [OW];
    logic [WordW-1:0] r_acc_mem  [OW];
    logic [OW-1:0]    r_base_vld;
    logic [OW-1:0]    r_exp_vld;
    logic [WordW-1:0] r_base_rd;
    logic [WordW-1:0] r_exp_rd;
    logic             r_base_rv;
    logic             r_exp_rv;

    // entry valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_vld <= '0;
            r_exp_vld  <= '0;
            r_base_rv  <= 1'b0;
            r_exp_rv   <= 1'b0;
        end else begin
            if (i_base_we) r_base_vld[i_ld_addr] <= 1'b1;
            if (i_exp_we)  r_exp_vld[i_ld_addr]  <= 1'b1;
            r_base_rv <= r_base_vld[i_base_ra];
            r_exp_rv  <= r_exp_vld[i_exp_ra];
        end
    end

    // base and exponent memories
    always_ff @(posedge i_clk) begin
        if (i_base_we) r_base_mem[i_ld_addr] <= i_ld_data;
        if (i_exp_we)  r_exp_mem[i_ld_addr]  <= i_ld_data;
        r_base_rd <= r_base_mem[i_base_ra];
        r_exp_rd  <= r_exp_mem[i_exp_ra];
    end

    // accumulator memory, one write and two read ports
    always_ff @(posedge i_clk) begin
        if (i_acc_we) r_acc_mem[i_acc_waddr] <= i_acc_wdata;
        o_acc_da <= r_acc_mem[i_acc_ra];
        o_acc_db <= r_acc_mem[i_acc_rb];
    end

    assign o_base_d = r_base_rv ? r_base_rd : '0;
    assign o_exp_d  = r_exp_rv  ? r_exp_rd  : '0;

endmodule

@@ sv/mexp_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_mul: column-scan multiplier
// Full double-width product of two operands, one 32x32 limb product per
// cycle, summed column by column; product words go to the reduction memory.
// ----------------------------------------------------------------------------
module mexp_mul #(
    parameter int OW = mexp_pkg::OpWordsDef,
    localparam int L   = 2 * OW,
    localparam int LW  = $clog2(L),
    localparam int AW  = LW - 1,
    localparam int PAW = LW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_square,
    output logic [AW-1:0]              o_a_addr,
    output logic [AW-1:0]              o_b_addr,
    input  logic [mexp_pkg::WordW-1:0] i_a_data,
    input  logic [mexp_pkg::WordW-1:0] i_b_acc_data,
    input  logic [mexp_pkg::WordW-1:0] i_b_base_data,
    output logic                       o_pw_en,
    output logic [PAW-1:0]             o_pw_addr,
    output logic [mexp_pkg::WordW-1:0] o_pw_data,
    output logic                       o_done,
    output logic                       o_busy
);
    import mexp_pkg::*;

    localparam int KW    = LW + 1;
    localparam int KLAST = 2 * L - 2;
    localparam int AccW  = WordW + LW + 1;

    // limb pair generator
    logic          r_gen;
    logic [KW-1:0] r_k;
    logic [LW-1:0] r_i;
    logic          r_sq;
    logic [LW-1:0] w_ihi;
    logic [KW-1:0] w_j;
    logic [KW-1:0] w_k1;
    logic [LW-1:0] w_ilo_n;
    logic          w_colend;
    logic          w_last;

    // stage 1: memory data, limb multiply
    logic           r_s1_v, r_s1_ah, r_s1_bh, r_s1_ce, r_s1_last, r_s1_kodd;
    logic [PAW-1:0] r_s1_kw;
    logic [LimbW-1:0] w_a_lim;
    logic [LimbW-1:0] w_b_lim;
    logic [WordW-1:0] w_b_word;

    // stage 2: column accumulate
    logic             r_s2_v, r_s2_ce, r_s2_last, r_s2_kodd;
    logic [PAW-1:0]   r_s2_kw;
    logic [WordW-1:0] r_prod;
    logic [AccW-1:0]  r_acc;
    logic [AccW-1:0]  w_sum;
    logic [LimbW-1:0] r_lo;

    assign w_ihi    = (r_k > KW'(L - 1)) ? LW'(L - 1) : r_k[LW-1:0];
    assign w_j      = r_k - {1'b0, r_i};
    assign w_k1     = r_k + KW'(1);
    assign w_ilo_n  = (w_k1 >= KW'(L)) ? LW'(w_k1 - KW'(L - 1)) : '0;
    assign w_colend = (r_i == w_ihi);
    assign w_last   = w_colend && (r_k == KW'(KLAST));

    assign o_a_addr = r_i[LW-1:1];
    assign o_b_addr = w_j[LW-1:1];

    // generator and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen  <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= r_gen;
            r_s2_v <= r_s1_v;
            if (i_start) begin
                r_gen <= 1'b1;
            end else if (r_gen && w_last) begin
                r_gen <= 1'b0;
            end
        end
    end

    // generator counters and stage tags
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k  <= '0;
            r_i  <= '0;
            r_sq <= i_square;
        end else if (r_gen) begin
            if (w_colend) begin
                r_k <= w_k1;
                r_i <= w_ilo_n;
            end else begin
                r_i <= r_i + LW'(1);
            end
        end
        r_s1_ah   <= r_i[0];
        r_s1_bh   <= w_j[0];
        r_s1_ce   <= w_colend;
        r_s1_last <= w_last;
        r_s1_kodd <= r_k[0];
        r_s1_kw   <= r_k[KW-1:1];
        r_s2_ce   <= r_s1_ce;
        r_s2_last <= r_s1_last;
        r_s2_kodd <= r_s1_kodd;
        r_s2_kw   <= r_s1_kw;
        r_prod    <= w_a_lim * w_b_lim;
    end

    // limb select
    assign w_b_word = r_sq ? i_b_acc_data : i_b_base_data;
    assign w_a_lim  = r_s1_ah ? i_a_data[WordW-1:LimbW] : i_a_data[LimbW-1:0];
    assign w_b_lim  = r_s1_bh ? w_b_word[WordW-1:LimbW] : w_b_word[LimbW-1:0];

    // column sum; a finished column gives one limb and carries the rest
    assign w_sum = r_acc + {{(AccW - WordW){1'b0}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_s2_v) begin
            r_acc <= r_s2_ce ? (w_sum >> LimbW) : w_sum;
            if (r_s2_ce && !r_s2_kodd && !r_s2_last) r_lo <= w_sum[LimbW-1:0];
        end
    end

    assign o_pw_en   = r_s2_v && r_s2_ce && (r_s2_kodd || r_s2_last);
    assign o_pw_addr = r_s2_kw;
    assign o_pw_data = r_s2_last ? w_sum[WordW-1:0] : {w_sum[LimbW-1:0], r_lo};
    assign o_done    = o_pw_en && r_s2_last;
    assign o_busy    = r_gen || r_s1_v || r_s2_v;

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("multiply started while busy");

    a_done_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("multiplier pipeline not empty after last word");

endmodule

@@ sv/mexp_red.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_red: bitwise reduction
// Holds the double-width product memory and reduces it by long division,
// one product bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module mexp_red #(
    parameter int OW = mexp_pkg::OpWordsDef,
    localparam int OPB = mexp_pkg::WordW * OW,
    localparam int PW  = 2 * OW,
    localparam int PAW = $clog2(PW)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [OPB-1:0]             i_mod,
    input  logic                       i_pw_en,
    input  logic [PAW-1:0]             i_pw_addr,
    input  logic [mexp_pkg::WordW-1:0] i_pw_data,
    output logic [OPB-1:0]             o_rem,
    output logic                       o_done,
    output logic                       o_busy
);
    import mexp_pkg::*;

    localparam int BW = $clog2(WordW);

    logic [WordW-1:0] r_pmem [PW];
    logic [WordW-1:0] r_prd;
    logic [PAW-1:0]   w_raddr;
    t_red_state       r_rstate, n_rstate;
    logic [PAW-1:0]   r_w;
    logic [BW-1:0]    r_b;
    logic [WordW-1:0] r_sh;
    logic [OPB-1:0]   r_rem;
    logic [OPB-1:0]   w_t;
    logic [OPB:0]     w_d;
    logic             w_take;
    logic             w_word_end;

    // product memory: next word is prefetched while the current one shifts
    assign w_raddr = (r_rstate == RD_PRE) ? r_w : r_w - PAW'(1);

    always_ff @(posedge i_clk) begin
        if (i_pw_en) r_pmem[i_pw_addr] <= i_pw_data;
        r_prd <= r_pmem[w_raddr];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rstate <= RD_IDLE;
        else          r_rstate <= n_rstate;
    end

    assign w_word_end = (r_b == '0);

    always_comb begin
        n_rstate = r_rstate;
        case (r_rstate)
            RD_IDLE: if (i_start) n_rstate = RD_PRE;
            RD_PRE:  n_rstate = RD_LOAD;
            RD_LOAD: n_rstate = RD_RUN;
            RD_RUN:  if (w_word_end && r_w == '0) n_rstate = RD_IDLE;
            default: n_rstate = RD_IDLE;
        endcase
    end

    // shift in one bit, subtract on overflow or when not below the modulus
    assign w_t    = {r_rem[OPB-2:0], r_sh[WordW-1]};
    assign w_d    = {1'b0, w_t} - {1'b0, i_mod};
    assign w_take = r_rem[OPB-1] | ~w_d[OPB];

    always_ff @(posedge i_clk) begin
        case (r_rstate)
            RD_IDLE: r_w <= PAW'(PW - 1);
            RD_LOAD: begin
                r_sh  <= r_prd;
                r_b   <= BW'(WordW - 1);
                r_rem <= '0;
            end
            RD_RUN: begin
                r_rem <= w_take ? w_d[OPB-1:0] : w_t;
                r_b   <= r_b - BW'(1);
                if (w_word_end) begin
                    r_w  <= r_w - PAW'(1);
                    r_sh <= r_prd;
                end else begin
                    r_sh <= r_sh << 1;
                end
            end
            default: ;
        endcase
    end

    assign o_rem  = r_rem;
    assign o_done = (r_rstate == RD_RUN) && w_word_end && (r_w == '0);
    assign o_busy = (r_rstate != RD_IDLE);

    // checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("reduction started while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pw_en |-> !o_busy)
        else $error("product written during reduction");

endmodule

@@ sv/modular_exponentiation_256.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_256: modular exponentiation engine
// Left-to-right square-and-multiply over 64*OPERAND_WORDS-bit operands with
// a column-scan multiplier and a bitwise long-division reduction.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | i_in_valid, o_in_stall, i_cmd,            | in
//           | i_word_index, i_word_value                |
//   output  | o_out_valid, i_out_stall, o_result_word,  | out
//           | o_result_index, o_last_word               |
//   config  | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
// A load is written on its transfer. In a start, a square is a launch, a
// multiply (at 256 bits, 64 limb products and two pipeline stages), a
// reduction (RD_PRE and RD_LOAD prime the product read, then one product
// bit a cycle), write back and exponent bit fetch; a multiply skips the
// fetch. Each result word is read in ST_OUT_RD, then offered in ST_OUT.
// Reset is synchronous, active low; base and exponent read as zero after it.
// The input is stalled for the whole of a start; a stalled result holds.
// ----------------------------------------------------------------------------
module modular_exponentiation_256 #(
    parameter int OPERAND_WORDS = mexp_pkg::OpWordsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [mexp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [mexp_pkg::WordW-1:0]   i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [mexp_pkg::CmdW-1:0]    i_cmd,
    input  logic [mexp_pkg::IdxW-1:0]    i_word_index,
    input  logic [mexp_pkg::WordW-1:0]   i_word_value,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [mexp_pkg::WordW-1:0]   o_result_word,
    output logic [mexp_pkg::IdxW-1:0]    o_result_index,
    output logic                         o_last_word
);
    import mexp_pkg::*;

    localparam int OW  = OPERAND_WORDS;
    localparam int AW  = $clog2(OW);
    localparam int OPB = WordW * OW;
    localparam int OBW = $clog2(OPB);
    localparam int PAW = $clog2(2 * OW);

    // modulus registers
    logic [WordW-1:0] r_mod [ModWords];
    logic [WordW*ModWords-1:0] w_mod_full;
    logic [OPB-1:0]   w_mod;
    logic [OPB-1:0]   w_inv;

    // sequencer
    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    logic [OBW-1:0] r_bit, n_bit;
    logic [AW-1:0]  r_k, n_k;
    logic           r_inv, n_inv;
    logic           w_mul_go, w_red_go, w_acc_we, w_adv;
    logic           w_in_xfer, w_idx_ok, w_ebit;

    // datapath links
    logic [AW-1:0]    w_mul_a_addr, w_mul_b_addr, w_acc_ra;
    logic [WordW-1:0] w_acc_da, w_acc_db, w_base_d, w_exp_d, w_acc_wdata;
    logic             w_pw_en, w_mul_done, w_mul_busy, w_red_done, w_red_busy;
    logic [PAW-1:0]   w_pw_addr;
    logic [WordW-1:0] w_pw_data;
    logic [OPB-1:0]   w_rem;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < ModWords; n++) r_mod[n] <= '0;
        end else if (i_cfg_we) begin
            r_mod[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_mod_full = {r_mod[3], r_mod[2], r_mod[1], r_mod[0]};
    assign w_mod      = w_mod_full[OPB-1:0];
    assign w_inv      = w_mod - OPB'(2);

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_idx_ok   = ({1'b0, i_word_index} < (IdxW + 1)'(OW));

    // exponent bit of the current step
    assign w_ebit = r_inv ? w_inv[r_bit] : w_exp_d[r_bit[5:0]];

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_INIT;
            r_bit   <= '0;
            r_k     <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_k     <= n_k;
            r_inv   <= n_inv;
        end
    end

    // next state and strobes
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_k      = r_k;
        n_inv    = r_inv;
        w_mul_go = 1'b0;
        w_red_go = 1'b0;
        w_acc_we = 1'b0;
        w_adv    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (i_cmd inside {CMD_POWER, CMD_INVERSE})) begin
                    n_inv   = (i_cmd == CMD_INVERSE);
                    n_bit   = OBW'(OPB - 1);
                    n_k     = '0;
                    n_phase = PH_INIT;
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                w_acc_we = 1'b1;
                if (r_k == AW'(OW - 1)) begin
                    n_k = '0;
                    case (r_phase)
                        PH_INIT: begin
                            n_phase = PH_SQR;
                            n_state = ST_MUL_GO;
                        end
                        PH_SQR:  n_state = ST_EXP_RD;
                        default: w_adv = 1'b1;
                    endcase
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            ST_MUL_GO: begin
                w_mul_go = 1'b1;
                n_state  = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (w_mul_done) begin
                    w_red_go = 1'b1;
                    n_state  = ST_RED_WAIT;
                end
            end
            ST_RED_WAIT: if (w_red_done) n_state = ST_WB;
            ST_EXP_RD:   n_state = ST_EXP_CHK;
            ST_EXP_CHK: begin
                if (w_ebit) begin
                    n_phase = PH_MUL;
                    n_state = ST_MUL_GO;
                end else begin
                    w_adv = 1'b1;
                end
            end
            ST_OUT_RD: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_out_stall) begin
                    if (r_k == AW'(OW - 1)) begin
                        n_k     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // move to the next exponent bit or to the result
        if (w_adv) begin
            if (r_bit == '0) begin
                n_k     = '0;
                n_state = ST_OUT_RD;
            end else begin
                n_bit   = r_bit - OBW'(1);
                n_phase = PH_SQR;
                n_state = ST_MUL_GO;
            end
        end
    end

    // accumulator write back: one at start, else the remainder
    assign w_acc_wdata = (r_phase == PH_INIT) ? ((r_k == '0) ? WordW'(1) : '0)
                                              : w_rem[r_k*WordW +: WordW];
    assign w_acc_ra    = (r_state == ST_OUT_RD || r_state == ST_OUT) ? r_k
                                                                     : w_mul_a_addr;

    mexp_store #(.OW(OW)) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base_we   (w_in_xfer && i_cmd == CMD_LOAD_BASE && w_idx_ok),
        .i_exp_we    (w_in_xfer && i_cmd == CMD_LOAD_EXP && w_idx_ok),
        .i_ld_addr   (i_word_index[AW-1:0]),
        .i_ld_data   (i_word_value),
        .i_acc_we    (w_acc_we),
        .i_acc_waddr (r_k),
        .i_acc_wdata (w_acc_wdata),
        .i_acc_ra    (w_acc_ra),
        .i_acc_rb    (w_mul_b_addr),
        .i_base_ra   (w_mul_b_addr),
        .i_exp_ra    (r_bit[OBW-1:6]),
        .o_acc_da    (w_acc_da),
        .o_acc_db    (w_acc_db),
        .o_base_d    (w_base_d),
        .o_exp_d     (w_exp_d)
    );

    mexp_mul #(.OW(OW)) u_mul (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_mul_go),
        .i_square      (r_phase == PH_SQR),
        .o_a_addr      (w_mul_a_addr),
        .o_b_addr      (w_mul_b_addr),
        .i_a_data      (w_acc_da),
        .i_b_acc_data  (w_acc_db),
        .i_b_base_data (w_base_d),
        .o_pw_en       (w_pw_en),
        .o_pw_addr     (w_pw_addr),
        .o_pw_data     (w_pw_data),
        .o_done        (w_mul_done),
        .o_busy        (w_mul_busy)
    );

    mexp_red #(.OW(OW)) u_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_red_go),
        .i_mod     (w_mod),
        .i_pw_en   (w_pw_en),
        .i_pw_addr (w_pw_addr),
        .i_pw_data (w_pw_data),
        .o_rem     (w_rem),
        .o_done    (w_red_done),
        .o_busy    (w_red_busy)
    );

    // result channel
    assign o_out_valid    = (r_state == ST_OUT);
    assign o_result_word  = w_acc_da;
    assign o_result_index = IdxW'(r_k);
    assign o_last_word    = (r_k == AW'(OW - 1));

    // checks
    a_red_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_red_go |=> !w_mul_busy)
        else $error("reduction began before the product was complete");

    a_wb_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_we |-> !w_mul_busy && !w_red_busy)
        else $error("accumulator written while a unit is running");

endmodule
